[design/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Shared widths, codes and types for the slotted page store.
// ----------------------------------------------------------------------------
package sps_pkg;

    // field widths of the item and result words
    localparam int KIND_W  = 2;
    localparam int SIDX_W  = 10;
    localparam int BIDX_W  = 12;
    localparam int RLEN_W  = 13;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 4;
    localparam int LEN_W   = 13;
    localparam int FREE_W  = 13;

    // default page geometry
    localparam int DEF_PAGE_SIZE   = 4096;
    localparam int DEF_HEADER_SIZE = 16;
    localparam int DEF_SLOT_SIZE   = 4;
    localparam int DEF_MAX_SLOTS   = 1024;

    // request kinds
    localparam logic [KIND_W-1:0] K_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] K_READ   = 2'd1;
    localparam logic [KIND_W-1:0] K_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] K_CLEAR  = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 4'd0;
    localparam logic [STAT_W-1:0] ST_TAKEN   = 4'd1;
    localparam logic [STAT_W-1:0] ST_NOROOM  = 4'd2;
    localparam logic [STAT_W-1:0] ST_DISCARD = 4'd3;
    localparam logic [STAT_W-1:0] ST_READOK  = 4'd4;
    localparam logic [STAT_W-1:0] ST_NOREC   = 4'd5;
    localparam logic [STAT_W-1:0] ST_BEYOND  = 4'd6;
    localparam logic [STAT_W-1:0] ST_DELETED = 4'd7;
    localparam logic [STAT_W-1:0] ST_CLEARED = 4'd8;

    // controller to datapath commands
    typedef struct packed {
        logic latch;   // word accepted: capture fields, read slot directory
        logic eval;    // update page state, write stores, start page read
        logic load;    // move result into the output register
    } t_cmd;

endpackage

[design/slotted_page_store.sv]
// A word is captured on accept, evaluated in the evaluate step and its result
// loaded in the result step (steps set by the registered reads of the slot
// directory and page byte store); the next word enters as that result loads.
// A full output register that is not taken holds off the next word.
// Reset is synchronous, active low: clears slot count, free space and insert
// progress; page bytes and slot directory are not cleared.
// ----------------------------------------------------------------------------
// slotted_page_store
// Slotted database page: byte-wise record insert, byte read, delete, clear.
// ----------------------------------------------------------------------------
module slotted_page_store
    import sps_pkg::*;
#(
    parameter int PAGE_SIZE   = DEF_PAGE_SIZE,
    parameter int HEADER_SIZE = DEF_HEADER_SIZE,
    parameter int SLOT_SIZE   = DEF_SLOT_SIZE,
    parameter int MAX_SLOTS   = DEF_MAX_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SIDX_W-1:0] i_slot_index,
    input  logic [BIDX_W-1:0] i_byte_index,
    input  logic [RLEN_W-1:0] i_record_length,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [SIDX_W-1:0] o_slot_number,
    output logic [LEN_W-1:0]  o_length_out,
    output logic [BYTE_W-1:0] o_byte_out,
    output logic [FREE_W-1:0] o_free_bytes
);

    t_cmd cmd;

    sps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    sps_dp #(
        .PAGE_SIZE   (PAGE_SIZE),
        .HEADER_SIZE (HEADER_SIZE),
        .SLOT_SIZE   (SLOT_SIZE),
        .MAX_SLOTS   (MAX_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_kind          (i_kind),
        .i_slot_index    (i_slot_index),
        .i_byte_index    (i_byte_index),
        .i_record_length (i_record_length),
        .i_data_byte     (i_data_byte),
        .o_status        (o_status),
        .o_slot_number   (o_slot_number),
        .o_length_out    (o_length_out),
        .o_byte_out      (o_byte_out),
        .o_free_bytes    (o_free_bytes)
    );

endmodule

[design/sps_ctrl.sv]
// ----------------------------------------------------------------------------
// sps_ctrl
// Sequencer for the page store: accept, evaluate, load result.
// ----------------------------------------------------------------------------
module sps_ctrl
    import sps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       accept;
    logic       load;

    always_comb begin
        out_free = !r_out_valid || i_ready;
        o_ready  = (r_state == S_IDLE) || ((r_state == S_FIN) && out_free);
        accept   = i_valid && o_ready;
        n_state  = r_state;
        load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                // next word may enter on the same edge the result leaves
                if (out_free) begin
                    load    = 1'b1;
                    n_state = accept ? S_EVAL : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = load ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_cmd.latch = accept;
    assign o_cmd.eval  = (r_state == S_EVAL);
    assign o_cmd.load  = load;

`ifndef SYNTHESIS
    a_eval_then_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |=> (r_state == S_FIN))
        else $error("evaluate step not followed by result step");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_out_valid)
        else $error("result loaded but output not valid");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_state == S_IDLE || r_state == S_FIN))
        else $error("word accepted while evaluating");
`endif

endmodule

[design/sps_dp.sv]
// ----------------------------------------------------------------------------
// sps_dp
// Page datapath: byte store, slot directory, space counters, result regs.
// ----------------------------------------------------------------------------
module sps_dp
    import sps_pkg::*;
#(
    parameter int PAGE_SIZE   = DEF_PAGE_SIZE,
    parameter int HEADER_SIZE = DEF_HEADER_SIZE,
    parameter int SLOT_SIZE   = DEF_SLOT_SIZE,
    parameter int MAX_SLOTS   = DEF_MAX_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SIDX_W-1:0] i_slot_index,
    input  logic [BIDX_W-1:0] i_byte_index,
    input  logic [RLEN_W-1:0] i_record_length,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic [STAT_W-1:0] o_status,
    output logic [SIDX_W-1:0] o_slot_number,
    output logic [LEN_W-1:0]  o_length_out,
    output logic [BYTE_W-1:0] o_byte_out,
    output logic [FREE_W-1:0] o_free_bytes
);

    localparam int AW  = $clog2(PAGE_SIZE);
    localparam int LW  = $clog2(PAGE_SIZE + 1);
    localparam int SIW = $clog2(MAX_SLOTS);
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int DW  = $clog2(HEADER_SIZE + MAX_SLOTS * SLOT_SIZE + 1);
    localparam int GW  = (DW > LW) ? DW : LW;
    localparam int XW  = ((GW > RLEN_W) ? GW : RLEN_W) + 1;
    localparam int PSW = ((LW > BIDX_W) ? LW : BIDX_W) + 1;
    localparam int SCW = (SIDX_W > CW) ? SIDX_W : CW;

    // stores
    logic [BYTE_W-1:0] r_page_mem [PAGE_SIZE];
    logic [LW-1:0]     r_off_mem  [MAX_SLOTS];
    logic [LW-1:0]     r_len_mem  [MAX_SLOTS];

    // captured word
    logic [KIND_W-1:0] r_kind;
    logic [SIDX_W-1:0] r_sidx;
    logic [BIDX_W-1:0] r_bidx;
    logic [RLEN_W-1:0] r_rlen;
    logic [BYTE_W-1:0] r_dbyte;
    logic [LW-1:0]     r_q_off, r_q_len;
    logic [BYTE_W-1:0] r_page_q;

    // page state
    logic [CW-1:0]     r_used, n_used;
    logic [LW-1:0]     r_low, n_low;
    logic [DW-1:0]     r_dir_end, n_dir_end;
    logic [RLEN_W-1:0] r_rcv, n_rcv;
    logic              r_disc, n_disc;
    logic [LW-1:0]     r_cur_off, n_cur_off;
    logic [LW-1:0]     r_cur_len, n_cur_len;

    // pending result
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [SIDX_W-1:0] r_res_slot, n_res_slot;
    logic [LEN_W-1:0]  r_res_len, n_res_len;
    logic              r_res_rd, n_res_rd;

    // output register
    logic [STAT_W-1:0] r_status;
    logic [SIDX_W-1:0] r_slot;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_byte;
    logic [FREE_W-1:0] r_free;

    logic [GW-1:0]     raw, free;
    logic              fits;
    logic [LW-1:0]     new_off, cont_pos;
    logic [RLEN_W-1:0] rcv_inc;
    logic [PSW-1:0]    rd_pos;
    logic              in_use;
    logic              finish;
    logic [LW-1:0]     fin_off;
    logic              dir_we, len_we, page_we, page_re;
    logic [SIW-1:0]    len_waddr;
    logic [LW-1:0]     len_wdata;
    logic [AW-1:0]     page_waddr;

    always_comb begin
        raw  = (GW'(r_low) > GW'(r_dir_end)) ? GW'(r_low) - GW'(r_dir_end) : '0;
        free = (raw > GW'(SLOT_SIZE)) ? raw - GW'(SLOT_SIZE) : '0;
        fits = (r_used < CW'(MAX_SLOTS)) && (XW'(r_rlen) <= XW'(free))
            && ((r_rlen != '0) || (raw >= GW'(SLOT_SIZE)));
        // rlen is no larger than free space whenever it is used here, so it fits LW
        new_off  = r_low - LW'(r_rlen);
        cont_pos = r_cur_off + LW'(r_rcv);
        rcv_inc  = r_rcv + RLEN_W'(1);
        rd_pos   = PSW'(r_q_off) + PSW'(r_bidx);
        in_use   = (SCW'(r_sidx) < SCW'(r_used)) && (r_q_len != '0);
    end

    always_comb begin
        n_used       = r_used;
        n_low        = r_low;
        n_dir_end    = r_dir_end;
        n_rcv        = r_rcv;
        n_disc       = r_disc;
        n_cur_off    = r_cur_off;
        n_cur_len    = r_cur_len;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_len    = r_res_len;
        n_res_rd     = r_res_rd;
        finish       = 1'b0;
        fin_off      = new_off;
        dir_we       = 1'b0;
        len_we       = 1'b0;
        len_waddr    = SIW'(r_used);
        len_wdata    = LW'(r_rlen);
        page_we      = 1'b0;
        page_waddr   = AW'(new_off);
        page_re      = 1'b0;
        if (i_cmd.eval) begin
            n_res_status = ST_DONE;
            n_res_slot   = '0;
            n_res_len    = '0;
            n_res_rd     = 1'b0;
            case (r_kind)
                K_INSERT: begin
                    if (r_disc) begin
                        // dropping the rest of a record that had no room
                        n_res_status = ST_DISCARD;
                        if (rcv_inc >= r_rlen) begin
                            n_disc = 1'b0;
                            n_rcv  = '0;
                        end else begin
                            n_rcv  = rcv_inc;
                        end
                    end else if (r_rcv == '0) begin
                        if (!fits) begin
                            n_res_status = ST_NOROOM;
                            n_res_len    = LEN_W'(r_rlen);
                            if (r_rlen > RLEN_W'(1)) begin
                                n_disc = 1'b1;
                                n_rcv  = RLEN_W'(1);
                            end
                        end else begin
                            dir_we     = 1'b1;
                            len_we     = 1'b1;
                            n_res_slot = SIDX_W'(r_used);
                            n_res_len  = LEN_W'(r_rlen);
                            n_cur_off  = new_off;
                            n_cur_len  = LW'(r_rlen);
                            if (r_rlen == '0) begin
                                n_res_status = ST_DONE;
                                finish       = 1'b1;
                            end else begin
                                page_we      = 1'b1;
                                n_rcv        = RLEN_W'(1);
                                n_res_status = ST_TAKEN;
                                if (r_rlen == RLEN_W'(1)) begin
                                    n_res_status = ST_DONE;
                                    finish       = 1'b1;
                                end
                            end
                        end
                    end else begin
                        // later byte of an accepted record
                        page_we      = 1'b1;
                        page_waddr   = AW'(cont_pos);
                        n_res_slot   = SIDX_W'(r_used);
                        n_res_len    = LEN_W'(r_cur_len);
                        n_rcv        = rcv_inc;
                        n_res_status = ST_TAKEN;
                        fin_off      = r_cur_off;
                        if (XW'(rcv_inc) >= XW'(r_cur_len)) begin
                            n_res_status = ST_DONE;
                            finish       = 1'b1;
                        end
                    end
                end
                K_READ, K_DELETE: begin
                    n_res_slot = r_sidx;
                    if (!in_use) begin
                        n_res_status = ST_NOREC;
                    end else if (r_kind == K_DELETE) begin
                        n_res_status = ST_DELETED;
                        n_res_len    = LEN_W'(r_q_len);
                        len_we       = 1'b1;
                        len_waddr    = SIW'(r_sidx);
                        len_wdata    = '0;
                    end else begin
                        n_res_len = LEN_W'(r_q_len);
                        if (PSW'(r_bidx) >= PSW'(r_q_len)) begin
                            n_res_status = ST_BEYOND;
                        end else begin
                            n_res_status = ST_READOK;
                            page_re      = rd_pos < PSW'(PAGE_SIZE);
                            n_res_rd     = page_re;
                        end
                    end
                end
                K_CLEAR: begin
                    n_res_status = ST_CLEARED;
                    n_used       = '0;
                    n_low        = LW'(PAGE_SIZE);
                    n_dir_end    = DW'(HEADER_SIZE);
                    n_rcv        = '0;
                    n_disc       = 1'b0;
                end
                default: begin
                end
            endcase
            if (finish) begin
                n_low     = fin_off;
                n_used    = r_used + CW'(1);
                n_dir_end = r_dir_end + DW'(SLOT_SIZE);
                n_rcv     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_low     <= LW'(PAGE_SIZE);
            r_dir_end <= DW'(HEADER_SIZE);
            r_rcv     <= '0;
            r_disc    <= 1'b0;
        end else begin
            r_used    <= n_used;
            r_low     <= n_low;
            r_dir_end <= n_dir_end;
            r_rcv     <= n_rcv;
            r_disc    <= n_disc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_off    <= n_cur_off;
        r_cur_len    <= n_cur_len;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_len    <= n_res_len;
        r_res_rd     <= n_res_rd;
        if (i_cmd.latch) begin
            r_kind  <= i_kind;
            r_sidx  <= i_slot_index;
            r_bidx  <= i_byte_index;
            r_rlen  <= i_record_length;
            r_dbyte <= i_data_byte;
        end
        if (i_cmd.load) begin
            r_status <= r_res_status;
            r_slot   <= r_res_slot;
            r_len    <= r_res_len;
            r_byte   <= r_res_rd ? r_page_q : '0;
            r_free   <= FREE_W'(free);
        end
    end

    // slot directory: read on accept, written during evaluate
    always_ff @(posedge i_clk) begin
        if (dir_we) r_off_mem[SIW'(r_used)] <= new_off;
        if (i_cmd.latch) r_q_off <= r_off_mem[SIW'(i_slot_index)];
    end

    always_ff @(posedge i_clk) begin
        if (len_we) r_len_mem[len_waddr] <= len_wdata;
        if (i_cmd.latch) r_q_len <= r_len_mem[SIW'(i_slot_index)];
    end

    always_ff @(posedge i_clk) begin
        if (page_we) r_page_mem[page_waddr] <= r_dbyte;
        if (page_re) r_page_q <= r_page_mem[AW'(rd_pos)];
    end

    assign o_status      = r_status;
    assign o_slot_number = r_slot;
    assign o_length_out  = r_len;
    assign o_byte_out    = r_byte;
    assign o_free_bytes  = r_free;

`ifndef SYNTHESIS
    a_disc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disc |-> (r_rcv != '0))
        else $error("discarding with zero byte count");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(MAX_SLOTS))
        else $error("slot count past directory size");
    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && r_kind == K_CLEAR) |=>
            (r_used == '0 && r_rcv == '0 && !r_disc && r_low == LW'(PAGE_SIZE)))
        else $error("clear left page counters set");
    a_discard_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && r_kind == K_INSERT && r_disc) |=> (r_res_status == ST_DISCARD))
        else $error("discarded byte reported with wrong status");
`endif

endmodule
